// File: src/lps_pkg.sv
// lps_pkg: shared types, field widths and codes of the led pattern sequencer
// used by every module under src; no dependencies
package lps_pkg;

    // field widths fixed by the item format
    localparam int IDX_W   = 6;
    localparam int LED_W   = 8;
    localparam int START_W = 6;
    localparam int LEN_W   = 7;
    localparam int DELAY_W = 16;
    localparam int POS_W   = 7;
    localparam int REP_W   = 8;
    localparam int CNT_W   = 4;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 8;

    // default storage depths
    localparam int DELTA_DEPTH_DEF = 64;
    localparam int SEQ_DEPTH_DEF   = 8;

    // LEDs actually driven; bits above this are never changed
    localparam int LED_COUNT = 8;
    localparam logic [LED_W-1:0] LED_BITS = LED_W'((64'd1 << LED_COUNT) - 64'd1);

    localparam logic [REP_W-1:0] REPEATS_RESET   = REP_W'(10);
    localparam logic [CNT_W-1:0] SEQ_COUNT_RESET = CNT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 2'd0,
        OP_WRITE_DELTA = 2'd1,
        OP_WRITE_SEQ   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEATS   = 2'd0,
        CFG_SEQ_COUNT = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [LED_W-1:0] mask;
        logic [LED_W-1:0] values;
    } delta_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [DELAY_W-1:0] delay;
    } desc_t;

endpackage

// File: src/led_pattern_sequencer.sv
// led_pattern_sequencer: top level with input register, result handshake and
// configuration registers; uses lps_pkg, lps_delta_mem, lps_seq_store, lps_engine
// An input transfer is held in the input register, then its result in the
// result register. Throughput: one item per cycle while m_tready does not stall the output,
// set by the delta memory read, which is prefetched at the address the next state points to.
// Reset: control state, configuration (repeats 10, sequence count 1), LEDs off and
// countdown zero; the delta and descriptor memories are undefined until written.
module led_pattern_sequencer #(
    parameter int DELTA_DEPTH = lps_pkg::DELTA_DEPTH_DEF,
    parameter int SEQ_DEPTH   = lps_pkg::SEQ_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[5:0], led_mask[13:6], led_values[21:14], seq_start[27:22],
    // seq_length[34:28], seq_delay[50:35], zero fill [55:51]
    input  logic [55:0]                       s_tdata,
    // operation[1:0]
    input  logic [lps_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // led_state[7:0]
    output logic [7:0]                        m_tdata,
    // changed[0]
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lps_pkg::CFG_W-1:0]         cfg_data
);
    import lps_pkg::*;

    localparam int ADDR_W = $clog2(DELTA_DEPTH);
    localparam int SEQ_W  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   idx_reg;
    delta_t             in_delta_reg;
    desc_t              in_desc_reg;
    logic [REP_W-1:0]   repeats_reg;
    logic [CNT_W-1:0]   seq_count_reg;

    logic               s_transfer;
    logic               out_free;
    logic               advance;
    logic               delta_wr_en;
    logic               seq_wr_en;
    logic [SEQ_W-1:0]   seq_next;
    logic [POS_W-1:0]   pos_next;
    logic [START_W-1:0] start_next;
    desc_t              cur_desc;
    delta_t             rd_delta;
    logic [LED_W-1:0]   led_state;
    logic               changed;

    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = in_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || out_free;
    assign s_transfer = s_tvalid && s_tready;

    assign delta_wr_en = advance && (op_reg == OP_WRITE_DELTA) && (32'(idx_reg) < DELTA_DEPTH);
    assign seq_wr_en   = advance && (op_reg == OP_WRITE_SEQ) && (32'(idx_reg) < SEQ_DEPTH);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_transfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            repeats_reg   <= REPEATS_RESET;
            seq_count_reg <= SEQ_COUNT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REPEATS:   repeats_reg   <= cfg_data;
                    CFG_SEQ_COUNT: seq_count_reg <= cfg_data[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (s_transfer)
        begin
            op_reg              <= s_tuser;
            idx_reg             <= s_tdata[5:0];
            in_delta_reg.mask   <= s_tdata[13:6];
            in_delta_reg.values <= s_tdata[21:14];
            in_desc_reg.start   <= s_tdata[27:22];
            in_desc_reg.length  <= s_tdata[34:28];
            in_desc_reg.delay   <= s_tdata[50:35];
        end
    end

    lps_delta_mem #(
        .DELTA_DEPTH (DELTA_DEPTH)
    ) u_delta_mem (
        .clk      (clk),
        .wr_en    (delta_wr_en),
        .wr_addr  (ADDR_W'(idx_reg)),
        .wr_delta (in_delta_reg),
        .rd_start (start_next),
        .rd_pos   (pos_next),
        .rd_delta (rd_delta)
    );

    lps_seq_store #(
        .SEQ_DEPTH (SEQ_DEPTH)
    ) u_seq_store (
        .clk        (clk),
        .wr_en      (seq_wr_en),
        .wr_idx     (SEQ_W'(idx_reg)),
        .wr_desc    (in_desc_reg),
        .rd_idx     (seq_next),
        .start_next (start_next),
        .cur_desc   (cur_desc)
    );

    lps_engine #(
        .SEQ_DEPTH (SEQ_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .operation (op_reg),
        .delta     (rd_delta),
        .cur_desc  (cur_desc),
        .repeats   (repeats_reg),
        .seq_count (seq_count_reg),
        .seq_next  (seq_next),
        .pos_next  (pos_next),
        .led_state (led_state),
        .changed   (changed)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = led_state;
    assign m_tuser  = changed;

endmodule

// File: src/lps_delta_mem.sv
// lps_delta_mem: delta entry memory with write-first registered read
// the read address is start plus position wrapped to the memory depth; uses lps_pkg
module lps_delta_mem #(
    parameter int DELTA_DEPTH = lps_pkg::DELTA_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DELTA_DEPTH)-1:0]  wr_addr,
    input  lps_pkg::delta_t                 wr_delta,
    input  logic [lps_pkg::START_W-1:0]     rd_start,
    input  logic [lps_pkg::POS_W-1:0]       rd_pos,
    output lps_pkg::delta_t                 rd_delta
);
    import lps_pkg::*;

    localparam int ADDR_W = $clog2(DELTA_DEPTH);
    localparam int SUM_W  = POS_W + 1;
    localparam int WRAP_N = 1 << SUM_W;

    delta_t            mem [DELTA_DEPTH];
    delta_t            rd_delta_reg;
    logic [SUM_W-1:0]  sum;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wrap_tab [WRAP_N];

    // constant table: sum modulo depth
    for (genvar g = 0; g < WRAP_N; g++)
    begin : g_wrap
        assign wrap_tab[g] = ADDR_W'(g % DELTA_DEPTH);
    end

    assign sum     = SUM_W'(rd_start) + SUM_W'(rd_pos);
    assign rd_addr = wrap_tab[sum];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_delta;
        end
        // forward a same-cycle write so the prefetch never goes stale
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_delta_reg <= wr_delta;
        end
        else
        begin
            rd_delta_reg <= mem[rd_addr];
        end
    end

    assign rd_delta = rd_delta_reg;

endmodule

// File: src/lps_seq_store.sv
// lps_seq_store: sequence descriptor store and the registered descriptor of
// the sequence that plays next; uses lps_pkg
module lps_seq_store #(
    parameter int SEQ_DEPTH = lps_pkg::SEQ_DEPTH_DEF
) (
    input  logic                                               clk,
    input  logic                                               wr_en,
    input  logic [((SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1)-1:0] wr_idx,
    input  lps_pkg::desc_t                                     wr_desc,
    input  logic [((SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1)-1:0] rd_idx,
    output logic [lps_pkg::START_W-1:0]                        start_next,
    output lps_pkg::desc_t                                     cur_desc
);
    import lps_pkg::*;

    desc_t store [SEQ_DEPTH];
    desc_t cur_desc_reg;
    desc_t cur_desc_next;

    always_comb
    begin
        if (wr_en && (wr_idx == rd_idx))
        begin
            cur_desc_next = wr_desc;
        end
        else
        begin
            cur_desc_next = store[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_idx] <= wr_desc;
        end
        cur_desc_reg <= cur_desc_next;
    end

    // start of the coming descriptor feeds the delta prefetch address
    assign start_next = cur_desc_next.start;
    assign cur_desc   = cur_desc_reg;

endmodule

// File: src/lps_engine.sv
// lps_engine: tick countdown, position, repeat and sequence state, the LED
// register and the changed flag of the result; uses lps_pkg
module lps_engine #(
    parameter int SEQ_DEPTH = lps_pkg::SEQ_DEPTH_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               advance,
    input  logic [lps_pkg::OP_W-1:0]                           operation,
    input  lps_pkg::delta_t                                    delta,
    input  lps_pkg::desc_t                                     cur_desc,
    input  logic [lps_pkg::REP_W-1:0]                          repeats,
    input  logic [lps_pkg::CNT_W-1:0]                          seq_count,
    output logic [((SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1)-1:0] seq_next,
    output logic [lps_pkg::POS_W-1:0]                          pos_next,
    output logic [lps_pkg::LED_W-1:0]                          led_state,
    output logic                                               changed
);
    import lps_pkg::*;

    localparam int SEQ_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int CW    = SEQ_W + 1;

    logic [LED_W-1:0]   led_reg, led_next;
    logic [SEQ_W-1:0]   seq_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [REP_W-1:0]   rep_reg, rep_next;
    logic [DELAY_W-1:0] ticks_reg, ticks_next;
    logic               changed_reg, changed_next;

    logic [LED_W-1:0]   mask;
    logic [POS_W:0]     pos_inc;
    logic [REP_W-1:0]   rep_inc;
    logic [REP_W-1:0]   reps_eff;
    logic [CW-1:0]      count_lim;
    logic [CW-1:0]      seq_inc;

    assign mask      = delta.mask & LED_BITS;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign rep_inc   = rep_reg + 1'b1;
    assign reps_eff  = (repeats == '0) ? REP_W'(1) : repeats;
    assign count_lim = (32'(seq_count) > SEQ_DEPTH) ? CW'(SEQ_DEPTH) : CW'(seq_count);
    assign seq_inc   = {1'b0, seq_reg} + 1'b1;

    always_comb
    begin
        led_next     = led_reg;
        seq_next     = seq_reg;
        pos_next     = pos_reg;
        rep_next     = rep_reg;
        ticks_next   = ticks_reg;
        changed_next = changed_reg;
        if (advance)
        begin
            changed_next = 1'b0;
            case (operation)
                OP_TICK:
                begin
                    if (ticks_reg != '0)
                    begin
                        ticks_next = ticks_reg - 1'b1;
                    end
                    else
                    begin
                        changed_next = 1'b1;
                        led_next     = (led_reg & ~mask) | (delta.values & mask);
                        ticks_next   = cur_desc.delay;
                        if (pos_inc >= {1'b0, cur_desc.length})
                        begin
                            // end of one play of the sequence
                            pos_next = '0;
                            if (rep_inc >= reps_eff)
                            begin
                                rep_next = '0;
                                seq_next = (seq_inc >= count_lim) ? '0 : seq_inc[SEQ_W-1:0];
                            end
                            else
                            begin
                                rep_next = rep_inc;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc[POS_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg     <= '0;
            seq_reg     <= '0;
            pos_reg     <= '0;
            rep_reg     <= '0;
            ticks_reg   <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            led_reg     <= led_next;
            seq_reg     <= seq_next;
            pos_reg     <= pos_next;
            rep_reg     <= rep_next;
            ticks_reg   <= ticks_next;
            changed_reg <= changed_next;
        end
    end

    // led and changed only move on advance, so they hold while the result stalls
    assign led_state = led_reg;
    assign changed   = changed_reg;

endmodule
